@@ rtl/iig_pkg.sv @@
// Shared types and constants for the integral image generator.
package iig_pkg;

    // Fixed field widths
    localparam int PIX_W = 8;
    localparam int SUM_W = 28;
    localparam int CFG_W = 11;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Size value that the registers take at reset
    localparam int RST_SIZE = 1024;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position flags that travel with one pixel
    typedef struct packed {
        logic first_row;
        logic last_in_row;
        logic last_in_frame;
    } iig_flags_t;

endpackage

@@ rtl/iig_line_store.sv @@
// Line store holding the previous row's area sums, one read and one write port.
module iig_line_store #(
    parameter int DEPTH = iig_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [iig_pkg::SUM_W-1:0] wr_data,
    output logic [iig_pkg::SUM_W-1:0] rd_data
);
    import iig_pkg::*;

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    // Write the new area sum of a column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/iig_frame_ctrl.sv @@
// Frame size registers, column and row counters and the running row sum.
module iig_frame_ctrl #(
    parameter int MAX_WIDTH  = iig_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iig_pkg::DEF_MAX_HEIGHT,
    parameter int AW         = $clog2(MAX_WIDTH),
    parameter int RSUM_W     = 18
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  iig_pkg::cfg_reg_t         cfg_index,
    input  logic [iig_pkg::CFG_W-1:0] cfg_data,
    input  logic                      advance,
    input  logic [iig_pkg::PIX_W-1:0] pixel,
    output logic [AW-1:0]             col,
    output logic [RSUM_W-1:0]         row_sum,
    output iig_pkg::iig_flags_t       flags
);
    import iig_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_W = (RST_SIZE > MAX_WIDTH) ? MAX_WIDTH : RST_SIZE;
    localparam int RST_H = (RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_SIZE;

    logic [WW-1:0]     width_reg,  width_next;
    logic [HW-1:0]     height_reg, height_next;
    logic [AW-1:0]     col_reg,    col_next;
    logic [RW-1:0]     row_reg,    row_next;
    logic [RSUM_W-1:0] rsum_reg,   rsum_next;
    logic              row_end;
    logic              frame_end;
    logic [RSUM_W-1:0] sum;

    // Clamp a written size into 1..limit
    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned limit);
        int unsigned r;
        r = 32'(v);
        if (v == '0)
        begin
            r = 1;
        end
        else if (r > limit)
        begin
            r = limit;
        end
        return r;
    endfunction

    // Decide position flags and the running sum for the current pixel
    always_comb
    begin
        row_end   = (WW'(col_reg) + WW'(1)) >= width_reg;
        frame_end = row_end && ((HW'(row_reg) + HW'(1)) >= height_reg);
        sum       = rsum_reg + RSUM_W'(pixel);
    end

    assign col                 = col_reg;
    assign row_sum             = sum;
    assign flags.first_row     = (row_reg == '0);
    assign flags.last_in_row   = row_end;
    assign flags.last_in_frame = frame_end;

    // Take size writes and advance counters on each accepted beat
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rsum_next   = rsum_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = WW'(clamp_size(cfg_data, MAX_WIDTH));
                REG_FRAME_HEIGHT: height_next = HW'(clamp_size(cfg_data, MAX_HEIGHT));
                default:          width_next  = width_reg;
            endcase
        end
        if (advance)
        begin
            if (row_end)
            begin
                col_next  = '0;
                rsum_next = '0;
                row_next  = frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next  = col_reg + AW'(1);
                rsum_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(RST_W);
            height_reg <= HW'(RST_H);
            col_reg    <= '0;
            row_reg    <= '0;
            rsum_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            rsum_reg   <= rsum_next;
        end
    end

endmodule

@@ rtl/integral_image_generator.sv @@
// Integral image generator: one summed-area value per raster-order pixel.
// Path: an accepted pixel beat is registered in the sum stage, then in the output register.
// Throughput: one pixel per cycle when not stalled, set by one line store read and one write
//   per cycle; a same-column read behind a pending write takes the new sum by forwarding.
// Reset: counters, running sum and valids clear, frame sizes return to 1024
//   (limited to the maximum); the line store is not cleared and needs no pass.
module integral_image_generator #(
    parameter int MAX_WIDTH  = iig_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iig_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  iig_pkg::cfg_reg_t         cfg_index,
    input  logic [iig_pkg::CFG_W-1:0] cfg_data,
    input  logic                      pixel_valid,
    output logic                      pixel_ready,
    input  logic [iig_pkg::PIX_W-1:0] pixel,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [iig_pkg::SUM_W-1:0] area_sum,
    output logic                      last_in_row,
    output logic                      last_in_frame
);
    import iig_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int RSUM_F = $clog2(MAX_WIDTH * ((1 << PIX_W) - 1) + 1);
    localparam int RSUM_W = (RSUM_F > SUM_W) ? SUM_W : RSUM_F;

    logic              accept;
    logic              s1_go;
    logic [AW-1:0]     col;
    logic [RSUM_W-1:0] row_sum;
    iig_flags_t        flags;
    logic [SUM_W-1:0]  rd_data;
    logic [SUM_W-1:0]  above;
    logic [SUM_W-1:0]  area;

    logic              s1_valid_reg, s1_valid_next;
    logic [AW-1:0]     s1_col_reg;
    logic [RSUM_W-1:0] s1_rsum_reg;
    iig_flags_t        s1_flags_reg;
    logic              fwd_hit_reg;
    logic [SUM_W-1:0]  fwd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  area_reg;
    logic              last_row_reg;
    logic              last_frame_reg;

    iig_frame_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW),
        .RSUM_W     (RSUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pixel     (pixel),
        .col       (col),
        .row_sum   (row_sum),
        .flags     (flags)
    );

    iig_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (area),
        .rd_data (rd_data)
    );

    // Advance the sum stage when the output register is free or draining
    assign s1_go       = s1_valid_reg && (!out_valid_reg || result_ready);
    assign pixel_ready = !s1_valid_reg || s1_go;
    assign accept      = pixel_valid && pixel_ready;

    // Add the sum above to the running row sum; forward a same-column write
    always_comb
    begin
        if (s1_flags_reg.first_row)
        begin
            above = '0;
        end
        else if (fwd_hit_reg)
        begin
            above = fwd_data_reg;
        end
        else
        begin
            above = rd_data;
        end
        area = above + SUM_W'(s1_rsum_reg);
    end

    // Track stage and output occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the accepted beat and the forwarding decision
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col;
            s1_rsum_reg  <= row_sum;
            s1_flags_reg <= flags;
            fwd_hit_reg  <= s1_go && (s1_col_reg == col);
            fwd_data_reg <= area;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            area_reg       <= area;
            last_row_reg   <= s1_flags_reg.last_in_row;
            last_frame_reg <= s1_flags_reg.last_in_frame;
        end
    end

    assign result_valid  = out_valid_reg;
    assign area_sum      = area_reg;
    assign last_in_row   = last_row_reg;
    assign last_in_frame = last_frame_reg;

`ifndef SYNTHESIS
    a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!last_in_frame || last_in_row))
        else $error("frame end flagged without row end");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result_ready) |-> !pixel_ready)
        else $error("pixel accepted while sum stage is stalled");

    a_forward_on_same_column: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_go && (s1_col_reg == col)) |=> (fwd_hit_reg && s1_valid_reg))
        else $error("same-column write not forwarded");

    a_beat_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> result_valid)
        else $error("sum stage advanced without loading the output");
`endif

endmodule
